// ----- hw/rtl/edd_pkg.sv -----
// Package for the error diffusion dither: item types, constants and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int LB_AW     = $clog2(MAX_WIDTH);
  localparam int QB_W      = 4;
  localparam int LW_W      = 12;
  localparam int CFG_W     = 12;

  localparam logic [QB_W-1:0] QB_RESET = 4'd1;
  localparam logic [QB_W-1:0] QB_MAX   = 4'd8;
  localparam logic [LW_W-1:0] LW_RESET = 12'd640;

  localparam logic REG_QUANT_BITS = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  // diffusion weights in sixteenths
  localparam logic [2:0] K_UL = 3'd1;
  localparam logic [2:0] K_UP = 3'd5;
  localparam logic [2:0] K_UR = 3'd3;
  localparam logic [2:0] K_LF = 3'd7;

  typedef logic signed [8:0] err_t;
  typedef err_t [2:0] err3_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic            d1_en;
    logic            d2_en;
    logic            ul_en;
    logic            up_en;
    logic            ur_en;
    logic            lf_en;
    logic [QB_W-1:0] bits;
  } edd_ctl_t;

  // clamp(v + floor(k*e/16), 0, 255)
  function automatic logic [7:0] diffuse(input logic [7:0] v, input logic [2:0] k,
                                         input err_t e);
    logic signed [12:0] ke;
    logic signed [12:0] s;
    ke = 13'(e) * $signed({10'b0, k});
    s  = $signed({5'b0, v}) + (ke >>> 4);
    if (s < 13'sd0) begin
      return 8'd0;
    end else if (s > 13'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [QB_W-1:0] clamp_bits(input logic [QB_W-1:0] b);
    if (b == '0) begin
      return QB_RESET;
    end else if (b > QB_MAX) begin
      return QB_MAX;
    end
    return b;
  endfunction

  // floor(lvl*255/(2^b-1)): bit replication, one less when the rotated level falls below it
  function automatic logic [7:0] recon(input logic [7:0] lvl, input logic [QB_W-1:0] b);
    logic [7:0] rep;
    logic [7:0] rot;
    rep = lvl;
    rot = lvl;
    unique case (b)
      4'd1: rep = {8{lvl[0]}};
      4'd2: rep = {4{lvl[1:0]}};
      4'd3: begin
        rep = {lvl[2:0], lvl[2:0], lvl[2:1]};
        rot = {5'b0, lvl[0], lvl[2:1]};
      end
      4'd4: rep = {2{lvl[3:0]}};
      4'd5: begin
        rep = {lvl[4:0], lvl[4:2]};
        rot = {3'b0, lvl[1:0], lvl[4:2]};
      end
      4'd6: begin
        rep = {lvl[5:0], lvl[5:4]};
        rot = {2'b0, lvl[3:0], lvl[5:4]};
      end
      4'd7: begin
        rep = {lvl[6:0], lvl[6]};
        rot = {1'b0, lvl[5:0], lvl[6]};
      end
      default: begin
        rep = lvl;
        rot = lvl;
      end
    endcase
    return (rot < lvl) ? rep - 8'd1 : rep;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/edd_line_buf.sv -----
// Line buffer holding the previous row's errors: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module edd_line_buf (
  input  wire logic                    clk,
  input  wire logic                    rd_en,
  input  wire logic [edd_pkg::LB_AW-1:0] rd_addr0,
  input  wire logic [edd_pkg::LB_AW-1:0] rd_addr1,
  input  wire logic                    wr_en,
  input  wire logic [edd_pkg::LB_AW-1:0] wr_addr,
  input  wire edd_pkg::err3_t          wr_data,
  output edd_pkg::err3_t               rd_data0_r,
  output edd_pkg::err3_t               rd_data1_r
);
  import edd_pkg::*;

  err3_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/edd_chan.sv -----
// One colour channel: two registered diffusion stages, then quantize and rebuild.
`timescale 1ns / 1ps
`default_nettype none

module edd_chan (
  input  wire logic             clk,
  input  wire edd_pkg::edd_ctl_t ctl,
  input  wire logic [7:0]       v,
  input  wire edd_pkg::err_t    e_ul,
  input  wire edd_pkg::err_t    e_up,
  input  wire edd_pkg::err_t    e_ur,
  input  wire edd_pkg::err_t    e_lf,
  output logic [7:0]            q,
  output edd_pkg::err_t         err
);
  import edd_pkg::*;

  logic [7:0] s1_r, s2_r;
  logic [7:0] a0, a1, b0, b1;
  logic [7:0] level;

  always_comb begin
    a0 = ctl.ul_en ? diffuse(v, K_UL, e_ul) : v;
    a1 = ctl.up_en ? diffuse(a0, K_UP, e_up) : a0;
    b0 = ctl.ur_en ? diffuse(s1_r, K_UR, e_ur) : s1_r;
    b1 = ctl.lf_en ? diffuse(b0, K_LF, e_lf) : b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.d1_en) begin
      s1_r <= a1;
    end
    if (ctl.d2_en) begin
      s2_r <= b1;
    end
  end

  assign level = s2_r >> (QB_MAX - ctl.bits);
  assign q     = recon(level, ctl.bits);
  assign err   = $signed({1'b0, s2_r}) - $signed({1'b0, q});

endmodule

`default_nettype wire

// ----- hw/rtl/error_diffusion_dither.sv -----
// Top level of the RGBA error diffusion dither with a row error line buffer.
//
//  port group  dir  handshake          payload
//  in_*        in   in_valid/in_stall   pix_in_t  (red, green, blue, alpha, frame_start)
//  out_*       out  out_valid/out_stall pix_out_t (red, green, blue, alpha)
//  cfg_*       in   cfg_wr_en           index 0 quant_bits, 1 line_width
//
//  Each item passes through these steps: accept with line buffer read, up-left/up step,
//  up-right/left step, quantize with line buffer write-back.
//  After reset a pass zeroes every line buffer entry; no item is taken meanwhile.
//  The result register holds while out_stall is high; the next item is worked
//  on meanwhile and waits in the last step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire edd_pkg::pix_in_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output edd_pkg::pix_out_t             out_data,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_index,
  input  wire logic [edd_pkg::CFG_W-1:0] cfg_wr_data
);
  import edd_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_D1   = 3'd2;
  localparam logic [2:0] ST_D2   = 3'd3;
  localparam logic [2:0] ST_Q    = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [QB_W-1:0]  quant_bits_r;
  logic [LW_W-1:0]  line_width_r;
  logic [LW_W-1:0]  w_eff;
  logic [LB_AW-1:0] clr_cnt_r;
  logic [LB_AW-1:0] col_r, c_r, c_acc;
  logic             row_first_r, first_acc;
  logic             last_r, ur_ok;
  logic             ul_en_r, up_en_r, ur_en_r, lf_en_r;
  logic [QB_W-1:0]  bits_r;
  err3_t            ul_r, left_r;
  err3_t            rd0, rd1, err3;
  pix_in_t          pix_r;
  pix_out_t         out_data_r;
  logic             out_valid_r;
  logic             accept, qdone;
  logic             wr_en;
  logic [LB_AW-1:0] wr_addr;
  err3_t            wr_data;
  edd_ctl_t         ctl;
  logic [2:0][7:0]  v_ch, q_ch;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign qdone     = (state_r == ST_Q) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_bits_r <= QB_RESET;
      line_width_r <= LW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_QUANT_BITS: quant_bits_r <= cfg_wr_data[QB_W-1:0];
        REG_LINE_WIDTH: line_width_r <= cfg_wr_data[LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width_r == '0) begin
      w_eff = LW_W'(1);
    end else if (int'(line_width_r) > MAX_WIDTH) begin
      w_eff = LW_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width_r;
    end
  end

  assign c_acc     = in_data.frame_start ? '0 : col_r;
  assign first_acc = in_data.frame_start || row_first_r;
  assign ur_ok     = (LW_W'(c_acc) + LW_W'(1)) < w_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_cnt_r == LB_AW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (accept) state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_Q;
      ST_Q:    if (qdone) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_first_r <= 1'b1;
      ul_r        <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + LB_AW'(1);
      end
      if (accept && in_data.frame_start) begin
        row_first_r <= 1'b1;
        ul_r        <= '0;
        left_r      <= '0;
      end
      if (qdone) begin
        ul_r   <= rd0;
        left_r <= err3;
        if (last_r) begin
          col_r       <= '0;
          row_first_r <= 1'b0;
        end else begin
          col_r <= c_r + LB_AW'(1);
        end
      end
      if (qdone) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r   <= in_data;
      c_r     <= c_acc;
      last_r  <= !ur_ok;
      bits_r  <= clamp_bits(quant_bits_r);
      ul_en_r <= !first_acc && (c_acc != '0);
      up_en_r <= !first_acc;
      ur_en_r <= !first_acc && ur_ok;
      lf_en_r <= (c_acc != '0);
    end
    if (qdone) begin
      out_data_r <= '{red_out: q_ch[0], green_out: q_ch[1], blue_out: q_ch[2],
                      alpha_out: pix_r.alpha_in};
    end
  end

  assign wr_en   = (state_r == ST_CLR) || qdone;
  assign wr_addr = (state_r == ST_CLR) ? clr_cnt_r : c_r;
  assign wr_data = (state_r == ST_CLR) ? '0 : err3;

  edd_line_buf u_line_buf (
    .clk        (clk),
    .rd_en      (accept),
    .rd_addr0   (c_acc),
    .rd_addr1   (c_acc + LB_AW'(1)),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data0_r (rd0),
    .rd_data1_r (rd1)
  );

  always_comb begin
    ctl.d1_en = (state_r == ST_D1);
    ctl.d2_en = (state_r == ST_D2);
    ctl.ul_en = ul_en_r;
    ctl.up_en = up_en_r;
    ctl.ur_en = ur_en_r;
    ctl.lf_en = lf_en_r;
    ctl.bits  = bits_r;
  end

  assign v_ch = {pix_r.blue_in, pix_r.green_in, pix_r.red_in};

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    edd_chan u_chan (
      .clk  (clk),
      .ctl  (ctl),
      .v    (v_ch[ch]),
      .e_ul (ul_r[ch]),
      .e_up (rd0[ch]),
      .e_ur (rd1[ch]),
      .e_lf (left_r[ch]),
      .q    (q_ch[ch]),
      .err  (err3[ch])
    );
  end

  a_wr_when_owned: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_CLR || state_r == ST_Q))
    else $error("line buffer written outside clear or write-back");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_D1))
    else $error("accepted item did not start diffusion");

  a_out_from_q: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_Q))
    else $error("result appeared without a write-back step");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.frame_start |=> row_first_r && left_r == '0 && ul_r == '0)
    else $error("frame start did not clear the row errors");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    qdone && !last_r |=> (LW_W'(col_r) < w_eff || $past(cfg_wr_en)))
    else $error("column ran past the line width");

endmodule

`default_nettype wire

// ----- tb/error_diffusion_dither_test.sv -----
// Testbench for the RGBA error diffusion dither: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module error_diffusion_dither_test;
  import edd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PIXELS = 1500;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic        reg_idx;
    logic [11:0] value;
    pix_in_t     px;
    logic        known;
    pix_out_t    want;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pix_out_t    out_data;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [11:0] cfg_wr_data;

  // predictor state
  int unsigned cur_bits = 1;
  int unsigned cur_width = 640;
  int          line_err [MAX_WIDTH][3];
  int          left_err [3];
  int          upleft_err [3];
  int unsigned col_pos = 0;
  bit          first_row = 1'b1;

  pix_out_t    pending_pixels [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  step_t       plan [$];

  error_diffusion_dither u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int nudge(int v, int k, int e);
    int s;
    s = (16 * v + k * e) >>> 4;
    if (s < 0) begin
      s = 0;
    end else if (s > 255) begin
      s = 255;
    end
    return s;
  endfunction

  task automatic dither_pixel(input pix_in_t px, output pix_out_t res);
    int unsigned nb;
    int unsigned w;
    int unsigned c;
    int          v;
    int          lvl;
    int          q;
    int          chan_in [3];
    logic [7:0]  chan_out [3];
    int          fresh [3];
    nb = cur_bits;
    if (nb < 1) nb = 1;
    if (nb > 8) nb = 8;
    w = cur_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (px.frame_start) begin
      col_pos = 0;
      first_row = 1'b1;
      left_err = '{0, 0, 0};
      upleft_err = '{0, 0, 0};
    end
    c = col_pos;
    chan_in = '{px.red_in, px.green_in, px.blue_in};
    for (int ch = 0; ch < 3; ch++) begin
      v = chan_in[ch];
      if (!first_row) begin
        if (c > 0) v = nudge(v, 1, upleft_err[ch]);
        v = nudge(v, 5, line_err[c][ch]);
        if (c + 1 < w) v = nudge(v, 3, line_err[c + 1][ch]);
      end
      if (c > 0) v = nudge(v, 7, left_err[ch]);
      lvl = v >> (8 - nb);
      q = (lvl * 255) / ((1 << nb) - 1);
      fresh[ch] = v - q;
      chan_out[ch] = q[7:0];
    end
    res = '{chan_out[0], chan_out[1], chan_out[2], px.alpha_in};
    for (int ch = 0; ch < 3; ch++) begin
      upleft_err[ch] = line_err[c][ch];
      line_err[c][ch] = fresh[ch];
      left_err[ch] = fresh[ch];
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      first_row = 1'b0;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic flag_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, results_seen, got, want);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] shade();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(0, 255));
    if (r < 85) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(120, 136));
  endfunction

  function automatic step_t free_px(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic fs);
    step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.px = '{r, g, b, a, fs};
    return s;
  endfunction

  function automatic step_t known_px(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a,
                                     input logic fs, input logic [7:0] ro,
                                     input logic [7:0] go, input logic [7:0] bo);
    step_t s;
    s = free_px(r, g, b, a, fs);
    s.known = 1'b1;
    s.want = '{ro, go, bo, a};
    return s;
  endfunction

  function automatic step_t reg_step(input logic idx, input logic [11:0] val);
    step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = val;
    return s;
  endfunction

  // entered and left just after a falling edge
  task automatic send_pixel(input pix_in_t px, input bit known, input pix_out_t want);
    pix_out_t guess;
    int unsigned g;
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = px;
    do @(posedge clk); while (in_stall);
    dither_pixel(px, guess);
    pending_pixels.push_back(known ? want : guess);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [11:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = val;
    @(posedge clk);
    if (idx == REG_QUANT_BITS) begin
      cur_bits = val[3:0];
    end else begin
      cur_width = val;
    end
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    pix_out_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        flag_mismatch("unexpected item", 1, 0);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_data.red_out !== exp_px.red_out)
          flag_mismatch("red_out", out_data.red_out, exp_px.red_out);
        if (out_data.green_out !== exp_px.green_out)
          flag_mismatch("green_out", out_data.green_out, exp_px.green_out);
        if (out_data.blue_out !== exp_px.blue_out)
          flag_mismatch("blue_out", out_data.blue_out, exp_px.blue_out);
        if (out_data.alpha_out !== exp_px.alpha_out)
          flag_mismatch("alpha_out", out_data.alpha_out, exp_px.alpha_out);
      end
    end
  end

  // receiver backpressure
  initial begin
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      run = pick_gap();
      if (!calm && run > 0) begin
        out_stall = 1'b1;
        repeat (run) @(negedge clk);
      end
      out_stall = 1'b0;
      repeat (1 + $urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned wr;
    int unsigned w_eff;
    int unsigned n;
    int unsigned flen;
    bit          new_frame;
    logic        fs;
    pix_in_t     px;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_QUANT_BITS;
    cfg_wr_data = '0;

    plan = '{
      known_px(8'd255, 8'd0, 8'd128, 8'hA5, 1'b1, 8'd255, 8'd0, 8'd255),
      free_px(8'd127, 8'd128, 8'd1, 8'h00, 1'b0),
      free_px(8'd255, 8'd255, 8'd255, 8'hFF, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd0),
      reg_step(REG_LINE_WIDTH, 12'd0),
      known_px(8'd200, 8'd50, 8'd0, 8'hFF, 1'b1, 8'd255, 8'd0, 8'd0),
      free_px(8'd100, 8'd100, 8'd100, 8'h07, 1'b0),
      free_px(8'd30, 8'd220, 8'd129, 8'h80, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd15),
      reg_step(REG_LINE_WIDTH, 12'd3),
      known_px(8'd0, 8'd255, 8'd77, 8'h5A, 1'b1, 8'd0, 8'd255, 8'd77),
      reg_step(REG_QUANT_BITS, 12'd2),
      free_px(8'd255, 8'd0, 8'd255, 8'h01, 1'b1),
      free_px(8'd0, 8'd255, 8'd0, 8'hFE, 1'b0),
      free_px(8'd128, 8'd127, 8'd64, 8'h02, 1'b0),
      free_px(8'd1, 8'd254, 8'd200, 8'h03, 1'b0),
      free_px(8'd255, 8'd255, 8'd0, 8'h04, 1'b0),
      free_px(8'd0, 8'd0, 8'd255, 8'h05, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd4),
      reg_step(REG_LINE_WIDTH, 12'd4095),
      known_px(8'd255, 8'd0, 8'd17, 8'h3C, 1'b1, 8'd255, 8'd0, 8'd17),
      free_px(8'd90, 8'd170, 8'd240, 8'h55, 1'b0),
      free_px(8'd10, 8'd245, 8'd128, 8'hAA, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd7),
      reg_step(REG_LINE_WIDTH, 12'd5),
      free_px(8'd60, 8'd200, 8'd99, 8'h11, 1'b1),
      free_px(8'd61, 8'd201, 8'd98, 8'h22, 1'b0),
      free_px(8'd62, 8'd202, 8'd97, 8'h33, 1'b0),
      free_px(8'd63, 8'd203, 8'd96, 8'h44, 1'b0),
      // width drops below the current column
      reg_step(REG_LINE_WIDTH, 12'd2),
      free_px(8'd64, 8'd204, 8'd95, 8'h66, 1'b0),
      free_px(8'd65, 8'd205, 8'd94, 8'h77, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd3),
      free_px(8'd150, 8'd40, 8'd222, 8'h88, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd5),
      free_px(8'd151, 8'd41, 8'd223, 8'h99, 1'b0),
      reg_step(REG_QUANT_BITS, 12'd6),
      free_px(8'd152, 8'd42, 8'd224, 8'hBB, 1'b0)
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        settle();
        reg_write(plan[i].reg_idx, plan[i].value);
      end else begin
        send_pixel(plan[i].px, plan[i].known, plan[i].want);
      end
    end

    n = pixels_sent;
    while (pixels_sent < n + RANDOM_PIXELS) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      wr = $urandom_range(0, 99);
      if (wr < 10) begin
        reg_write(REG_QUANT_BITS, $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(9, 15)));
      end else begin
        reg_write(REG_QUANT_BITS, 12'($urandom_range(1, 8)));
      end
      wr = $urandom_range(0, 99);
      if (wr < 2) reg_write(REG_LINE_WIDTH, 12'd0);
      else if (wr < 4) reg_write(REG_LINE_WIDTH, 12'd2048);
      else if (wr < 6) reg_write(REG_LINE_WIDTH, 12'($urandom_range(2049, 4095)));
      else if (wr < 8) reg_write(REG_LINE_WIDTH, 12'($urandom_range(17, 700)));
      else reg_write(REG_LINE_WIDTH, 12'($urandom_range(1, 16)));
      w_eff = (cur_width < 1) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
      flen = w_eff * $urandom_range(1, 6);
      new_frame = $urandom_range(0, 1);
      wr = (w_eff > 16) ? $urandom_range(10, 40) : $urandom_range(20, 120);
      for (int unsigned i = 0; i < wr; i++) begin
        fs = (new_frame && (i % flen == 0)) || ($urandom_range(0, 39) == 0);
        px = '{shade(), shade(), shade(), 8'($urandom_range(0, 255)), fs};
        send_pixel(px, 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (pending_pixels.size() != 0) flag_mismatch("items never returned",
                                                  pending_pixels.size(), 0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
